/* rtl/core/mbrsp_pkg.sv */
`default_nettype none

package mbrsp_pkg;

    // Widths
    localparam int POS_W      = 10;
    localparam int SLOT_W     = 2;
    localparam int OFF_W      = 4;
    localparam int ADDR_W     = 6;
    localparam int COUNT_W    = 3;
    localparam int ENTRY_DEPTH = 64;

    // Sector layout
    localparam int SECTOR_BYTES = 512;
    localparam logic [POS_W-1:0] ENTRY_BASE   = 10'd446;
    localparam logic [POS_W-1:0] ENTRY_END    = 10'd510;
    localparam logic [POS_W-1:0] SIG_LOW_POS  = 10'd510;
    localparam logic [POS_W-1:0] SIG_HIGH_POS = 10'd511;
    localparam logic [POS_W-1:0] FULL_POS     = POS_W'(SECTOR_BYTES - 1);
    localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

    // Offsets inside one 16-byte entry
    localparam logic [OFF_W-1:0] OFF_STATUS = 4'd0;
    localparam logic [OFF_W-1:0] OFF_TYPE   = 4'd4;
    localparam logic [OFF_W-1:0] OFF_START  = 4'd8;
    localparam logic [OFF_W-1:0] OFF_LAST   = 4'd15;

    localparam logic [SLOT_W-1:0] FIRST_SLOT = 2'd0;
    localparam logic [SLOT_W-1:0] LAST_SLOT  = 2'd3;

    // Byte values
    localparam logic [7:0] SIG_LOW_VAL   = 8'h55;
    localparam logic [7:0] SIG_HIGH_VAL  = 8'hAA;
    localparam logic [7:0] BOOT_ACTIVE   = 8'h80;
    localparam logic [7:0] TYPE_EMPTY    = 8'h00;
    localparam logic [7:0] TYPE_EXT_CHS  = 8'h05;
    localparam logic [7:0] TYPE_EXT_LBA  = 8'h0F;
    localparam logic [7:0] TYPE_EXT_LNX  = 8'h85;
    localparam logic [7:0] TYPE_GPT_PROT = 8'hEE;

    localparam logic REC_ENTRY   = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        TBL_NONE = 2'd0,
        TBL_MBR  = 2'd1,
        TBL_GPT  = 2'd2
    } table_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TYPE,
        ST_FIELD,
        ST_EMIT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic        accept;
        logic        capture_type;
        logic        set_table;
        table_kind_t table_val;
        logic        next_slot;
        logic        field_start;
        logic        field_step;
        logic        emit_record;
        logic        emit_summary;
        logic        clear_run;
    } ctrl_cmd_t;

    typedef struct packed {
        logic judge_ok;
        logic type_gpt;
        logic type_skip;
        logic slot_first;
        logic slot_last;
        logic off_last;
    } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/mbrsp_ram.sv */
`default_nettype none

module mbrsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/mbrsp_ctrl.sv */
`default_nettype none

module mbrsp_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   end_of_sector,
    input  wire mbrsp_pkg::dp_status_t  status,
    output mbrsp_pkg::ctrl_cmd_t        cmd,
    output logic                        busy
);

    mbrsp_pkg::state_t state_reg;
    mbrsp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbrsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.table_val = mbrsp_pkg::TBL_NONE;
        busy       = 1'b1;

        case (state_reg)
            mbrsp_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (end_of_sector)
                    begin
                        state_next = mbrsp_pkg::ST_TYPE;
                    end
                end
            end

            // Read data holds the type byte of the current slot.
            mbrsp_pkg::ST_TYPE:
            begin
                cmd.capture_type = 1'b1;
                if (status.slot_first && !status.judge_ok)
                begin
                    cmd.set_table = 1'b1;
                    cmd.table_val = mbrsp_pkg::TBL_NONE;
                    state_next    = mbrsp_pkg::ST_SUMMARY;
                end
                else if (status.slot_first && status.type_gpt)
                begin
                    cmd.set_table = 1'b1;
                    cmd.table_val = mbrsp_pkg::TBL_GPT;
                    state_next    = mbrsp_pkg::ST_SUMMARY;
                end
                else
                begin
                    if (status.slot_first)
                    begin
                        cmd.set_table = 1'b1;
                        cmd.table_val = mbrsp_pkg::TBL_MBR;
                    end
                    if (status.type_skip)
                    begin
                        if (status.slot_last)
                        begin
                            state_next = mbrsp_pkg::ST_SUMMARY;
                        end
                        else
                        begin
                            cmd.next_slot = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.field_start = 1'b1;
                        state_next      = mbrsp_pkg::ST_FIELD;
                    end
                end
            end

            mbrsp_pkg::ST_FIELD:
            begin
                cmd.field_step = 1'b1;
                if (status.off_last)
                begin
                    state_next = mbrsp_pkg::ST_EMIT;
                end
            end

            mbrsp_pkg::ST_EMIT:
            begin
                cmd.emit_record = 1'b1;
                if (status.slot_last)
                begin
                    state_next = mbrsp_pkg::ST_SUMMARY;
                end
                else
                begin
                    cmd.next_slot = 1'b1;
                    state_next    = mbrsp_pkg::ST_TYPE;
                end
            end

            mbrsp_pkg::ST_SUMMARY:
            begin
                cmd.emit_summary = 1'b1;
                cmd.clear_run    = 1'b1;
                state_next       = mbrsp_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = mbrsp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/mbrsp_datapath.sv */
`default_nettype none

module mbrsp_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           sector_byte,
    input  wire mbrsp_pkg::ctrl_cmd_t cmd,
    output mbrsp_pkg::dp_status_t     status,
    output logic                      result_strobe,
    output logic                      record_kind,
    output logic [1:0]                entry_slot,
    output logic [31:0]               start_sector,
    output logic [31:0]               sector_total,
    output logic [7:0]                type_code,
    output logic                      boot_flag,
    output logic [1:0]                table_kind,
    output logic [2:0]                found_count,
    output logic                      last_result
);

    // Run state
    logic [mbrsp_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                    sig_low_reg, sig_low_next;
    logic [7:0]                    sig_high_reg, sig_high_next;
    logic                          full_reg, full_next;
    logic [mbrsp_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [mbrsp_pkg::OFF_W-1:0]   off_reg, off_next;
    logic [mbrsp_pkg::COUNT_W-1:0] count_reg, count_next;
    mbrsp_pkg::table_kind_t        table_reg, table_next;

    // Entry fields being gathered
    logic [7:0]  type_reg;
    logic        boot_reg;
    logic [31:0] start_reg;
    logic [31:0] total_reg;

    // Result registers
    logic        strobe_reg;
    logic        kind_out_reg;
    logic [1:0]  slot_out_reg;
    logic [31:0] start_out_reg;
    logic [31:0] total_out_reg;
    logic [7:0]  type_out_reg;
    logic        boot_out_reg;
    logic [1:0]  table_out_reg;
    logic [2:0]  count_out_reg;
    logic        last_out_reg;

    logic                          in_entries;
    logic                          ram_we;
    logic [mbrsp_pkg::POS_W-1:0]   pos_rel;
    logic [mbrsp_pkg::ADDR_W-1:0]  ram_waddr;
    logic [mbrsp_pkg::ADDR_W-1:0]  ram_raddr;
    logic [7:0]                    ram_rdata;

    assign in_entries = (pos_reg >= mbrsp_pkg::ENTRY_BASE) && (pos_reg < mbrsp_pkg::ENTRY_END);
    assign ram_we     = cmd.accept && in_entries;
    assign pos_rel    = pos_reg - mbrsp_pkg::ENTRY_BASE;
    assign ram_waddr  = pos_rel[mbrsp_pkg::ADDR_W-1:0];
    // Address the byte that the next cycle works on.
    assign ram_raddr  = {slot_next, off_next};

    mbrsp_ram #(
        .WIDTH (8),
        .DEPTH (mbrsp_pkg::ENTRY_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sector_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_next      = pos_reg;
        sig_low_next  = sig_low_reg;
        sig_high_next = sig_high_reg;
        full_next     = full_reg;
        slot_next     = slot_reg;
        off_next      = off_reg;
        count_next    = count_reg;
        table_next    = table_reg;

        if (cmd.accept)
        begin
            if (pos_reg == mbrsp_pkg::SIG_LOW_POS)
            begin
                sig_low_next = sector_byte;
            end
            if (pos_reg == mbrsp_pkg::SIG_HIGH_POS)
            begin
                sig_high_next = sector_byte;
            end
            if (pos_reg != mbrsp_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
            full_next  = (pos_reg >= mbrsp_pkg::FULL_POS);
            slot_next  = mbrsp_pkg::FIRST_SLOT;
            off_next   = mbrsp_pkg::OFF_TYPE;
            count_next = '0;
        end

        if (cmd.set_table)
        begin
            table_next = cmd.table_val;
        end

        if (cmd.next_slot)
        begin
            slot_next = slot_reg + 1'b1;
            off_next  = mbrsp_pkg::OFF_TYPE;
        end

        if (cmd.field_start)
        begin
            off_next = mbrsp_pkg::OFF_STATUS;
        end

        // Walk status byte, then bytes 8 to 15; hold on the last one.
        if (cmd.field_step && (off_reg != mbrsp_pkg::OFF_LAST))
        begin
            if (off_reg == mbrsp_pkg::OFF_STATUS)
            begin
                off_next = mbrsp_pkg::OFF_START;
            end
            else
            begin
                off_next = off_reg + 1'b1;
            end
        end

        if (cmd.emit_record)
        begin
            count_next = count_reg + 1'b1;
        end

        if (cmd.clear_run)
        begin
            pos_next      = '0;
            sig_low_next  = '0;
            sig_high_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sig_low_reg  <= '0;
            sig_high_reg <= '0;
            full_reg     <= 1'b0;
            slot_reg     <= '0;
            off_reg      <= '0;
            count_reg    <= '0;
            table_reg    <= mbrsp_pkg::TBL_NONE;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            sig_low_reg  <= sig_low_next;
            sig_high_reg <= sig_high_next;
            full_reg     <= full_next;
            slot_reg     <= slot_next;
            off_reg      <= off_next;
            count_reg    <= count_next;
            table_reg    <= table_next;
            strobe_reg   <= cmd.emit_record || cmd.emit_summary;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture_type)
        begin
            type_reg <= ram_rdata;
        end
        if (cmd.field_step)
        begin
            if (off_reg == mbrsp_pkg::OFF_STATUS)
            begin
                boot_reg <= (ram_rdata == mbrsp_pkg::BOOT_ACTIVE);
            end
            else if (off_reg[3:2] == 2'b10)
            begin
                start_reg <= {ram_rdata, start_reg[31:8]};
            end
            else if (off_reg[3:2] == 2'b11)
            begin
                total_reg <= {ram_rdata, total_reg[31:8]};
            end
        end

        if (cmd.emit_record)
        begin
            kind_out_reg  <= mbrsp_pkg::REC_ENTRY;
            slot_out_reg  <= slot_reg;
            start_out_reg <= start_reg;
            total_out_reg <= total_reg;
            type_out_reg  <= type_reg;
            boot_out_reg  <= boot_reg;
            table_out_reg <= mbrsp_pkg::TBL_NONE;
            count_out_reg <= '0;
            last_out_reg  <= 1'b0;
        end
        else if (cmd.emit_summary)
        begin
            kind_out_reg  <= mbrsp_pkg::REC_SUMMARY;
            slot_out_reg  <= '0;
            start_out_reg <= '0;
            total_out_reg <= '0;
            type_out_reg  <= '0;
            boot_out_reg  <= 1'b0;
            table_out_reg <= table_reg;
            count_out_reg <= count_reg;
            last_out_reg  <= 1'b1;
        end
    end

    assign status.judge_ok   = full_reg && (sig_low_reg == mbrsp_pkg::SIG_LOW_VAL)
                               && (sig_high_reg == mbrsp_pkg::SIG_HIGH_VAL);
    assign status.type_gpt   = (ram_rdata == mbrsp_pkg::TYPE_GPT_PROT);
    assign status.type_skip  = (ram_rdata == mbrsp_pkg::TYPE_EMPTY)
                               || (ram_rdata == mbrsp_pkg::TYPE_EXT_CHS)
                               || (ram_rdata == mbrsp_pkg::TYPE_EXT_LBA)
                               || (ram_rdata == mbrsp_pkg::TYPE_EXT_LNX);
    assign status.slot_first = (slot_reg == mbrsp_pkg::FIRST_SLOT);
    assign status.slot_last  = (slot_reg == mbrsp_pkg::LAST_SLOT);
    assign status.off_last   = (off_reg == mbrsp_pkg::OFF_LAST);

    assign result_strobe = strobe_reg;
    assign record_kind   = kind_out_reg;
    assign entry_slot    = slot_out_reg;
    assign start_sector  = start_out_reg;
    assign sector_total  = total_out_reg;
    assign type_code     = type_out_reg;
    assign boot_flag     = boot_out_reg;
    assign table_kind    = table_out_reg;
    assign found_count   = count_out_reg;
    assign last_result   = last_out_reg;

endmodule

`default_nettype wire

/* rtl/core/mbr_sector_parser.sv */
`default_nettype none

// Partition table parser for sector zero of a disk.
//
// Input: drive start high with one byte of the sector on sector_byte, in
// ascending offset order; an item is taken on a clock edge where start is
// high and busy is low. Mark the final byte with end_of_sector. Every byte
// but the final one leaves busy low, so a stream of one byte per cycle flows
// straight through. Bytes 446..509 land in a 64-entry RAM, bytes 510 and 511
// in the signature registers.
// After the final byte busy stays high while a sequencer walks the four
// primary entries through the RAM's single read port: a skipped entry reads
// only its type byte, a used entry its type, status and eight field bytes
// before its record is emitted; the summary comes last. With no table or a GPT
// protective entry in the first slot the walk goes straight to the summary.
// busy drops in the cycle that carries the summary strobe.
// Output: each result is valid for one cycle while result_strobe is high; the
// receiver cannot stall, so take every strobed item. Partition records come
// first, then the summary, flagged by last_result.
// Reset returns the sequencer to idle and clears the byte offset and the
// signature; the entry RAM keeps whatever it held.
module mbr_sector_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [7:0]  sector_byte,
    input  wire logic        end_of_sector,
    output logic             busy,
    output logic             result_strobe,
    output logic             record_kind,
    output logic [1:0]       entry_slot,
    output logic [31:0]      start_sector,
    output logic [31:0]      sector_total,
    output logic [7:0]       type_code,
    output logic             boot_flag,
    output logic [1:0]       table_kind,
    output logic [2:0]       found_count,
    output logic             last_result
);

    mbrsp_pkg::ctrl_cmd_t  cmd;
    mbrsp_pkg::dp_status_t status;
    logic                  accept;

    assign accept = start && !busy;

    // Sequencer: accepts bytes, then steps the entry walk.
    mbrsp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .end_of_sector (end_of_sector),
        .status        (status),
        .cmd           (cmd),
        .busy          (busy)
    );

    // Offset counter, signature, entry RAM, field gathering and result registers.
    mbrsp_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .sector_byte   (sector_byte),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .record_kind   (record_kind),
        .entry_slot    (entry_slot),
        .start_sector  (start_sector),
        .sector_total  (sector_total),
        .type_code     (type_code),
        .boot_flag     (boot_flag),
        .table_kind    (table_kind),
        .found_count   (found_count),
        .last_result   (last_result)
    );

    // Results come only out of a walk.
    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result strobe without a preceding walk");

    // A byte that does not close the sector leaves the block free.
    a_plain_byte_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_sector) |=> !busy)
        else $error("busy after a non-final byte");

    // The summary closes the run; nothing follows it directly.
    a_summary_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (record_kind == mbrsp_pkg::REC_SUMMARY)) |=> !result_strobe)
        else $error("result right after the summary");

    // Never more records than primary slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_result) |-> (found_count <= 3'd4))
        else $error("found count out of range");

endmodule

`default_nettype wire
